/* src/utx_pkg.sv */
// Package for the 8N1 UART transmitter with byte FIFO.
// Holds the FIFO sizing constants and the input and result word types.
// No dependencies.
package utx_pkg;

  localparam int unsigned FIFO_DEPTH = 1024;
  localparam int unsigned PTR_W      = $clog2(FIFO_DEPTH);
  localparam int unsigned CNT_W      = $clog2(FIFO_DEPTH + 1);
  localparam int unsigned FILL_W     = 11;
  localparam int unsigned BYTE_W     = 8;

  // Frame position of the stop bit; positions 1 to 8 carry the data bits.
  localparam logic [3:0] STOP_IDX = 4'd9;

  typedef enum logic {
    FUNC_TICK = 1'b0,
    FUNC_PUSH = 1'b1
  } func_e;

  typedef struct packed {
    func_e             func;
    logic [BYTE_W-1:0] data;
  } in_word_t;

  typedef struct packed {
    logic              tx_line;
    logic              idle;
    logic              dropped;
    logic [FILL_W-1:0] fill_level;
  } out_word_t;

endpackage

/* src/uart_tx_serializer_fifo.sv */
// 8N1 UART transmitter with a byte FIFO kept in a synchronous RAM.
// The result of an accepted word sits in the output register in the next cycle.
// Throughput: one word per cycle; only a stalled, full output register holds off input.
// Reset clears the pointers, count and frame state and sets the line high; the FIFO
// RAM is not cleared, since entries are only read after they have been written.
// Depends on utx_pkg and utx_ram.
module uart_tx_serializer_fifo import utx_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_word_t  in_word_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_word_t out_word_o
);

  logic [PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [BYTE_W-1:0] frame_byte_q;
  logic [3:0]        bit_idx_q, bit_idx_d;
  logic              active_q, active_d;
  logic              line_q, line_d;
  logic              rd_pend_q;
  logic              out_valid_q;
  out_word_t         out_word_q, out_word_d;

  logic              accept;
  logic              push, pop;
  logic              full;
  logic              idle;
  logic [2:0]        bit_sel;
  logic [BYTE_W-1:0] rdata;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign full       = (count_q == CNT_W'(FIFO_DEPTH));
  assign push       = accept && (in_word_i.func == FUNC_PUSH) && !full;
  assign pop        = accept && (in_word_i.func == FUNC_TICK) && !active_q && (count_q != '0);
  assign bit_sel    = 3'(bit_idx_q - 4'd1);

  utx_ram #(
    .Width(BYTE_W),
    .Depth(FIFO_DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (push),
    .waddr_i(wr_ptr_q),
    .wdata_i(in_word_i.data),
    .re_i   (pop),
    .raddr_i(rd_ptr_q),
    .rdata_o(rdata)
  );

  always_comb begin
    rd_ptr_d  = rd_ptr_q;
    wr_ptr_d  = wr_ptr_q;
    count_d   = count_q;
    bit_idx_d = bit_idx_q;
    active_d  = active_q;
    line_d    = line_q;
    idle      = 1'b0;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      count_d  = count_q + 1'b1;
    end else if (pop) begin
      rd_ptr_d  = (rd_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      count_d   = count_q - 1'b1;
      bit_idx_d = '0;
      active_d  = 1'b1;
    end else if (accept && (in_word_i.func == FUNC_TICK)) begin
      if (active_q) begin
        if (bit_idx_q == '0) begin
          line_d = 1'b0;
        end else if (bit_idx_q < STOP_IDX) begin
          line_d = frame_byte_q[bit_sel];
        end else begin
          line_d   = 1'b1;
          active_d = 1'b0;
        end
        bit_idx_d = bit_idx_q + 4'd1;
      end else begin
        line_d = 1'b1;
        idle   = 1'b1;
      end
    end
  end

  always_comb begin
    out_word_d.tx_line    = line_d;
    out_word_d.idle       = idle;
    out_word_d.dropped    = accept && (in_word_i.func == FUNC_PUSH) && full;
    out_word_d.fill_level = FILL_W'(count_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q    <= '0;
      wr_ptr_q    <= '0;
      count_q     <= '0;
      bit_idx_q   <= '0;
      active_q    <= 1'b0;
      line_q      <= 1'b1;
      rd_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      rd_ptr_q  <= rd_ptr_d;
      wr_ptr_q  <= wr_ptr_d;
      count_q   <= count_d;
      bit_idx_q <= bit_idx_d;
      active_q  <= active_d;
      line_q    <= line_d;
      rd_pend_q <= pop;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // The popped byte comes from the RAM's registered read port in the cycle after the pop. The first tick
  // after a pop only sends the start bit, so the byte is in place before any data bit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_byte_q <= '0;
    end else if (rd_pend_q) begin
      frame_byte_q <= rdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_word_q <= out_word_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

/* src/utx_ram.sv */
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
module utx_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* test/tb_uart_tx_serializer_fifo.sv */
// Self-checking testbench for the 8N1 UART transmitter with byte FIFO.
// Drives random byte pushes and baud ticks under random valid/stall idling and
// checks every result word against a built-in shadow of the serializer. Needs utx_pkg and uart_tx_serializer_fifo.
module tb_uart_tx_serializer_fifo import utx_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_AT        = 600;
  localparam int HOLD_CYCLES    = 300;
  localparam int MAX_PRINTED    = 50;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_stall_o;
  in_word_t  in_word_i   = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_word_t out_word_o;

  uart_tx_serializer_fifo DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

  always #5 clk_i = ~clk_i;

  // Shadow of the transmitter state.
  logic [BYTE_W-1:0] shadow_fifo [FIFO_DEPTH];
  int unsigned       shadow_rd    = 0;
  int unsigned       shadow_wr    = 0;
  int unsigned       shadow_count = 0;
  logic [BYTE_W-1:0] shadow_frame = '0;
  logic [3:0]        shadow_pos   = '0;
  logic              shadow_busy  = 1'b0;
  logic              shadow_line  = 1'b1;

  in_word_t  words_to_send [$];
  out_word_t line_results_due [$];

  int n_sent = 0, n_results = 0, n_errors = 0;
  int n_pushes = 0, n_ticks = 0, n_drops = 0, n_idles = 0, n_frames = 0, peak_fill = 0;
  int send_wait = 0, recv_wait = 0, quiet_cycles = 0;
  bit send_burst = 1'b0, recv_burst = 1'b0;

  // Advances the shadow by one word and returns the result the block must give.
  function automatic out_word_t serialize_step(in_word_t w);
    out_word_t r;
    r = '0;
    if (w.func == FUNC_PUSH) begin
      n_pushes++;
      if (shadow_count < FIFO_DEPTH) begin
        shadow_fifo[shadow_wr] = w.data;
        shadow_wr = (shadow_wr == FIFO_DEPTH - 1) ? 0 : shadow_wr + 1;
        shadow_count++;
      end else begin
        r.dropped = 1'b1;
        n_drops++;
      end
    end else begin
      n_ticks++;
      if (shadow_busy) begin
        if (shadow_pos == 4'd0) begin
          shadow_line = 1'b0;
        end else if (shadow_pos < STOP_IDX) begin
          shadow_line = shadow_frame[shadow_pos - 4'd1];
        end else begin
          shadow_line = 1'b1;
          shadow_busy = 1'b0;
        end
        shadow_pos = shadow_pos + 4'd1;
      end else if (shadow_count != 0) begin
        // A pop only loads the byte; the start bit goes out on the next tick.
        shadow_frame = shadow_fifo[shadow_rd];
        shadow_rd = (shadow_rd == FIFO_DEPTH - 1) ? 0 : shadow_rd + 1;
        shadow_count--;
        shadow_pos = 4'd0;
        shadow_busy = 1'b1;
        n_frames++;
      end else begin
        shadow_line = 1'b1;
        r.idle = 1'b1;
        n_idles++;
      end
    end
    r.tx_line = shadow_line;
    r.fill_level = FILL_W'(shadow_count);
    if (shadow_count > peak_fill) peak_fill = shadow_count;
    return r;
  endfunction

  function automatic in_word_t make_word(bit push, logic [BYTE_W-1:0] d);
    in_word_t w;
    w.func = push ? FUNC_PUSH : FUNC_TICK;
    w.data = d;
    return w;
  endfunction

  // Printing stops after a while so a broken block does not flood the log.
  task automatic report_mismatch(string what, out_word_t got, out_word_t want);
    if (n_errors < MAX_PRINTED)
      $display({"MISMATCH result %0d (%s): got line=%b idle=%b drop=%b fill=%0d, ",
                "want line=%b idle=%b drop=%b fill=%0d"},
               n_results, what, got.tx_line, got.idle, got.dropped, got.fill_level,
               want.tx_line, want.idle, want.dropped, want.fill_level);
    n_errors++;
  endtask

  // Sender: one word from the pending queue at a time, with a random gap after each.
  always @(posedge clk_i) begin : driver
    int gap;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        line_results_due.push_back(serialize_step(in_word_i));
        n_sent++;
        if ($urandom_range(0, 39) == 0) send_burst = ~send_burst;
        gap = send_burst ? 0 : $urandom_range(0, 14);
        if (gap == 0 && words_to_send.size() > 0) begin
          in_word_i <= words_to_send.pop_front();
        end else begin
          in_valid_i <= 1'b0;
          send_wait  <= gap;
        end
      end else if (!in_valid_i) begin
        if (send_wait > 0) begin
          send_wait <= send_wait - 1;
        end else if (words_to_send.size() > 0) begin
          in_word_i  <= words_to_send.pop_front();
          in_valid_i <= 1'b1;
        end
      end
    end
  end

  // Receiver: checks each result word, then stalls for a random number of cycles.
  always @(posedge clk_i) begin : monitor
    int hold;
    out_word_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (line_results_due.size() == 0) begin
          report_mismatch("nothing outstanding", out_word_o, '0);
        end else begin
          want = line_results_due.pop_front();
          if (out_word_o.tx_line !== want.tx_line || out_word_o.idle !== want.idle ||
              out_word_o.dropped !== want.dropped ||
              out_word_o.fill_level !== want.fill_level)
            report_mismatch("field", out_word_o, want);
        end
        n_results++;
        if ($urandom_range(0, 39) == 0) recv_burst = ~recv_burst;
        // One long hold-off lets the block back up and stall the sender.
        if (n_results == HOLD_AT) hold = HOLD_CYCLES;
        else hold = recv_burst ? 0 : $urandom_range(0, 14);
        recv_wait   <= hold;
        out_stall_i <= (hold != 0);
      end else if (recv_wait > 0) begin
        recv_wait   <= recv_wait - 1;
        out_stall_i <= (recv_wait > 1);
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Timeout: no word moved for %0d cycles", WATCHDOG_LIMIT);
      $display("uart_tx_serializer_fifo regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic drain();
    while (words_to_send.size() > 0 || in_valid_i || line_results_due.size() > 0)
      @(posedge clk_i);
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: idle tick, then two frames of all-zero and all-one data back to back.
    words_to_send.push_back(make_word(1'b0, 8'hFF));
    words_to_send.push_back(make_word(1'b1, 8'h00));
    words_to_send.push_back(make_word(1'b1, 8'hFF));
    for (int i = 0; i < 22; i++)
      words_to_send.push_back(make_word(1'b0, BYTE_W'($urandom_range(0, 255))));
    drain();

    // Tick-heavy traffic: the FIFO stays shallow, frames run and the line goes idle.
    for (int i = 0; i < 60; i++)
      words_to_send.push_back(make_word($urandom_range(0, 11) == 0,
                                        BYTE_W'($urandom_range(0, 255))));
    drain();

    // Push-heavy traffic: fills the FIFO to the top, then further bytes are dropped.
    for (int i = 0; i < 1065; i++)
      words_to_send.push_back(make_word($urandom_range(0, 63) != 0,
                                        BYTE_W'($urandom_range(0, 255))));
    drain();
    repeat (5) @(posedge clk_i);

    $display("Sent %0d words (%0d pushes, %0d ticks), checked %0d results.",
             n_sent, n_pushes, n_ticks, n_results);
    $display("Saw %0d frames, %0d idle ticks, %0d dropped bytes, peak fill %0d.",
             n_frames, n_idles, n_drops, peak_fill);
    if (n_errors == 0) begin
      $display("uart_tx_serializer_fifo regression: pass");
    end else begin
      $display("%0d mismatches", n_errors);
      $display("uart_tx_serializer_fifo regression: fail");
    end
    $finish;
  end

endmodule

/* files.f */
src/utx_pkg.sv
src/utx_ram.sv
src/uart_tx_serializer_fifo.sv
test/tb_uart_tx_serializer_fifo.sv
